/* src/deadline_timer_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// Deadline timer scheduler assertion macros
// Shared property wrappers clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_SCHEDULER_DEFINES_SVH
`define DEADLINE_TIMER_SCHEDULER_DEFINES_SVH

// check a plain property every cycle outside reset
`define DTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check an implication every cycle outside reset
`define DTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/dts_pkg.sv */
// ----------------------------------------------------------------------------
// Deadline timer scheduler package
// Sizes, operation and result codes, slot record and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  localparam int unsigned Slots    = 16;
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned MaxOut   = 16;
  localparam int unsigned CntW     = $clog2(MaxOut + 1);
  localparam int unsigned FuncW    = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned IdW      = 32;
  localparam int unsigned DelayW   = 32;
  localparam int unsigned TimeW    = 48;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_ADD     = 3'd1,
    FUNC_ADD_PER = 3'd2,
    FUNC_CANCEL  = 3'd3,
    FUNC_STOP    = 3'd4
  } func_e;

  localparam logic [KindW-1:0] KIND_ID     = 2'd0;
  localparam logic [KindW-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KindW-1:0] KIND_FIRED  = 2'd2;

  typedef enum logic [1:0] {
    RES_ADD,
    RES_CANCEL,
    RES_FIRE
  } res_sel_e;

  typedef struct packed {
    logic [IdW-1:0]    task_id;
    logic [TimeW-1:0]  deadline;
    logic [DelayW-1:0] period;
    logic              repeats;
  } slot_t;

  typedef struct packed {
    logic     capture;
    logic     tick_adv;
    logic     set_halt;
    logic     scan_start;
    logic     take;
    logic     do_add;
    logic     push;
    logic     push_last;
    res_sel_e push_sel;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  halted;
    logic  scan_done;
    logic  best_found;
    logic  best_cancelled;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/dts_if.sv */
// ----------------------------------------------------------------------------
// Deadline timer scheduler channels
// Request and response valid/ready interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface dts_req_if;
  logic                      valid;
  logic                      ready;
  logic [dts_pkg::FuncW-1:0]  func;
  logic [dts_pkg::DelayW-1:0] delay_ticks;
  logic [dts_pkg::IdW-1:0]    cancel_id;

  modport source (output valid, func, delay_ticks, cancel_id, input ready);
  modport sink (input valid, func, delay_ticks, cancel_id, output ready);
endinterface

interface dts_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [dts_pkg::KindW-1:0] kind;
  logic [dts_pkg::IdW-1:0]   task_id;
  logic                      ok;
  logic                      last;

  modport source (output valid, kind, task_id, ok, last, input ready);
  modport sink (input valid, kind, task_id, ok, last, output ready);
endinterface

`default_nettype wire

/* src/dts_datapath.sv */
// ----------------------------------------------------------------------------
// Deadline timer scheduler datapath
// Slot table, clock and id counter, slot scanner and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deadline_timer_scheduler_defines.svh"

module dts_datapath (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire dts_pkg::cmd_t         cmd_i,
  output dts_pkg::sts_t              sts_o,
  input  wire [dts_pkg::FuncW-1:0]   func_i,
  input  wire [dts_pkg::DelayW-1:0]  delay_ticks_i,
  input  wire [dts_pkg::IdW-1:0]     cancel_id_i,
  input  wire                        out_ready_i,
  output logic                       out_valid_o,
  output logic [dts_pkg::KindW-1:0]  kind_o,
  output logic [dts_pkg::IdW-1:0]    task_id_o,
  output logic                       ok_o,
  output logic                       last_o
);
  import dts_pkg::*;

  slot_t              mem_q [Slots];
  logic [Slots-1:0]   valid_q, cancelled_q;
  logic [FuncW-1:0]   func_q;
  logic [DelayW-1:0]  delay_q;
  logic [IdW-1:0]     cid_q;
  logic [TimeW-1:0]   now_q;
  logic [IdW-1:0]     next_id_q;
  logic               halted_q;

  logic               scan_act_q;
  logic [SlotW-1:0]   scan_idx_q;
  logic               cmp_v_q;
  logic [SlotW-1:0]   cmp_idx_q;
  slot_t              rd_q;
  logic               done_q;

  logic               best_found_q;
  logic               best_canc_q;
  logic [SlotW-1:0]   best_idx_q;
  slot_t              best_q;
  logic               found_q, fresh_q;
  logic [IdW-1:0]     pend_id_q;

  logic               out_valid_q;
  logic [KindW-1:0]   kind_q;
  logic [IdW-1:0]     task_q;
  logic               ok_q;
  logic               last_q;

  logic               full;
  logic [SlotW-1:0]   free_idx;
  logic [DelayW-1:0]  eff_delay;
  logic               is_per;
  logic               out_free;
  logic               cand_due, cand_better, cand_match;
  logic [IdW-1:0]     next_id_inc;
  slot_t              add_rec, reload_rec;

  always_comb begin
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  assign full        = &valid_q;
  assign is_per      = (func_q == FUNC_ADD_PER);
  assign eff_delay   = (is_per && delay_q == '0) ? DelayW'(1) : delay_q;
  assign next_id_inc = (next_id_q + IdW'(1) == '0) ? IdW'(1) : next_id_q + IdW'(1);
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    add_rec.task_id    = next_id_q;
    add_rec.deadline   = now_q + TimeW'(eff_delay);
    add_rec.period     = is_per ? eff_delay : '0;
    add_rec.repeats    = is_per;
    reload_rec          = best_q;
    reload_rec.deadline = now_q + TimeW'(best_q.period);
  end

  assign cand_due    = valid_q[cmp_idx_q] && (rd_q.deadline <= now_q);
  assign cand_better = !best_found_q || (rd_q.deadline < best_q.deadline) ||
                       (rd_q.deadline == best_q.deadline && rd_q.task_id < best_q.task_id);
  assign cand_match  = valid_q[cmp_idx_q] && (rd_q.task_id == cid_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add && !halted_q && !full) begin
      mem_q[free_idx] <= add_rec;
    end else if (cmd_i.take && !best_canc_q && best_q.repeats) begin
      mem_q[best_idx_q] <= reload_rec;
    end
    rd_q <= mem_q[scan_idx_q];
    if (cmd_i.capture) begin
      delay_q <= delay_ticks_i;
      cid_q   <= cancel_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cancelled_q  <= '0;
      func_q       <= '0;
      now_q        <= '0;
      next_id_q    <= IdW'(1);
      halted_q     <= 1'b0;
      scan_act_q   <= 1'b0;
      scan_idx_q   <= '0;
      cmp_v_q      <= 1'b0;
      cmp_idx_q    <= '0;
      done_q       <= 1'b0;
      best_found_q <= 1'b0;
      best_canc_q  <= 1'b0;
      best_idx_q   <= '0;
      best_q       <= '0;
      found_q      <= 1'b0;
      fresh_q      <= 1'b0;
      pend_id_q    <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= '0;
      task_q       <= '0;
      ok_q         <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        func_q <= func_i;
      end
      if (cmd_i.tick_adv) begin
        now_q <= now_q + TimeW'(1);
      end
      if (cmd_i.set_halt) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.do_add) begin
        next_id_q <= next_id_inc;
        if (!halted_q && !full) begin
          valid_q[free_idx]     <= 1'b1;
          cancelled_q[free_idx] <= 1'b0;
        end
      end

      done_q  <= cmp_v_q && (cmp_idx_q == SlotW'(Slots - 1));
      cmp_v_q <= scan_act_q;
      cmp_idx_q <= scan_idx_q;
      if (cmd_i.scan_start) begin
        scan_act_q   <= 1'b1;
        scan_idx_q   <= '0;
        best_found_q <= 1'b0;
        found_q      <= 1'b0;
        fresh_q      <= 1'b0;
      end else if (scan_act_q) begin
        if (scan_idx_q == SlotW'(Slots - 1)) begin
          scan_act_q <= 1'b0;
        end else begin
          scan_idx_q <= scan_idx_q + SlotW'(1);
        end
      end

      if (cmp_v_q && !cmd_i.scan_start) begin
        if (func_q == FUNC_CANCEL) begin
          if (cand_match) begin
            found_q                <= 1'b1;
            cancelled_q[cmp_idx_q] <= 1'b1;
            if (!cancelled_q[cmp_idx_q]) begin
              fresh_q <= 1'b1;
            end
          end
        end else if (cand_due && cand_better) begin
          best_found_q <= 1'b1;
          best_canc_q  <= cancelled_q[cmp_idx_q];
          best_idx_q   <= cmp_idx_q;
          best_q       <= rd_q;
        end
      end

      if (cmd_i.take) begin
        if (best_canc_q) begin
          valid_q[best_idx_q]     <= 1'b0;
          cancelled_q[best_idx_q] <= 1'b0;
        end else begin
          pend_id_q <= best_q.task_id;
          if (!best_q.repeats) begin
            valid_q[best_idx_q] <= 1'b0;
          end
        end
      end

      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
        last_q      <= cmd_i.push_last;
        case (cmd_i.push_sel)
          RES_ADD: begin
            kind_q <= KIND_ID;
            task_q <= (halted_q || full) ? '0 : next_id_q;
            ok_q   <= !(halted_q || full);
          end
          RES_CANCEL: begin
            kind_q <= KIND_CANCEL;
            task_q <= cid_q;
            ok_q   <= !found_q || fresh_q;
          end
          RES_FIRE: begin
            kind_q <= KIND_FIRED;
            task_q <= pend_id_q;
            ok_q   <= 1'b1;
          end
          default: begin
            kind_q <= KIND_ID;
            task_q <= '0;
            ok_q   <= 1'b0;
          end
        endcase
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.func           = func_e'(func_q);
    sts_o.halted         = halted_q;
    sts_o.scan_done      = done_q;
    sts_o.best_found     = best_found_q;
    sts_o.best_cancelled = best_canc_q;
    sts_o.out_free       = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign task_id_o   = task_q;
  assign ok_o        = ok_q;
  assign last_o      = last_q;

  `DTS_ASSERT_IMPL(a_push_free, cmd_i.push, out_free, "push into a busy output register")
  `DTS_ASSERT_IMPL(a_start_idle, cmd_i.scan_start, !scan_act_q && !cmp_v_q, "scan restarted")
  `DTS_ASSERT_IMPL(a_take_found, cmd_i.take, best_found_q && !scan_act_q, "take without a due slot")
  `DTS_ASSERT(a_id_nonzero, next_id_q != '0, "id counter reached zero")

endmodule

`default_nettype wire

/* src/dts_ctrl.sv */
// ----------------------------------------------------------------------------
// Deadline timer scheduler controller
// Sequences dispatch, slot scans, firing rounds and result pushes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deadline_timer_scheduler_defines.svh"

module dts_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire dts_pkg::sts_t  sts_i,
  output dts_pkg::cmd_t       cmd_o
);
  import dts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD,
    ST_CSCAN,
    ST_CPUSH,
    ST_TSCAN,
    ST_FIRE,
    ST_FINAL
  } state_e;

  state_e           state_q, state_d;
  logic             pend_q, pend_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.push_sel = RES_ADD;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.func)
          FUNC_TICK: begin
            cmd_o.tick_adv = 1'b1;
            if (sts_i.halted) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.scan_start = 1'b1;
              pend_d  = 1'b0;
              cnt_d   = '0;
              state_d = ST_TSCAN;
            end
          end
          FUNC_ADD, FUNC_ADD_PER: state_d = ST_ADD;
          FUNC_CANCEL: begin
            cmd_o.scan_start = 1'b1;
            state_d = ST_CSCAN;
          end
          FUNC_STOP: begin
            cmd_o.set_halt = 1'b1;
            state_d = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ADD: begin
        if (sts_i.out_free) begin
          cmd_o.do_add    = 1'b1;
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          cmd_o.push_sel  = RES_ADD;
          state_d = ST_IDLE;
        end
      end
      ST_CSCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_CPUSH;
        end
      end
      ST_CPUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          cmd_o.push_sel  = RES_CANCEL;
          state_d = ST_IDLE;
        end
      end
      ST_TSCAN: begin
        if (sts_i.scan_done) begin
          if (!sts_i.best_found) begin
            state_d = pend_q ? ST_FINAL : ST_IDLE;
          end else if (sts_i.best_cancelled) begin
            cmd_o.take       = 1'b1;
            cmd_o.scan_start = 1'b1;
          end else begin
            state_d = ST_FIRE;
          end
        end
      end
      ST_FIRE: begin
        if (!pend_q || sts_i.out_free) begin
          cmd_o.push     = pend_q;
          cmd_o.push_sel = RES_FIRE;
          cmd_o.take     = 1'b1;
          pend_d = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
          if (cnt_q + CntW'(1) == CntW'(MaxOut)) begin
            state_d = ST_FINAL;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = ST_TSCAN;
          end
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          cmd_o.push_sel  = RES_FIRE;
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  `DTS_ASSERT(a_cnt_cap, cnt_q <= CntW'(MaxOut), "fire count above cap")
  `DTS_ASSERT_IMPL(a_final_pend, state_q == ST_FINAL, pend_q, "final push with nothing pending")
  `DTS_ASSERT_IMPL(a_accept_idle, in_valid_i && in_ready_o, state_q == ST_IDLE, "busy accept")

endmodule

`default_nettype wire

/* src/deadline_timer_scheduler.sv */
// ----------------------------------------------------------------------------
// Deadline timer scheduler
// Sixteen-slot one-shot and periodic timer table with earliest-deadline firing.
// ----------------------------------------------------------------------------
// One request is processed at a time. A cancel makes one pass over the slot
// table. A tick makes one scan pass per entry taken plus a closing pass, which
// is skipped once MaxOut entries have fired; the slot memory is read one slot
// per cycle during a pass. Fired results stream out with last marking the
// final one of each tick; a stalled output holds the controller. No clearing
// pass follows reset.
`default_nettype none

module deadline_timer_scheduler (
  input  wire        clk_i,
  input  wire        rst_ni,
  dts_req_if.sink    req,
  dts_rsp_if.source  rsp
);
  import dts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dts_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (req.func),
    .delay_ticks_i (req.delay_ticks),
    .cancel_id_i   (req.cancel_id),
    .out_ready_i   (rsp.ready),
    .out_valid_o   (rsp.valid),
    .kind_o        (rsp.kind),
    .task_id_o     (rsp.task_id),
    .ok_o          (rsp.ok),
    .last_o        (rsp.last)
  );

endmodule

`default_nettype wire
